[design/slfl_pkg.sv]
// Shared types and constants for the sorted list with free list block.
// No dependencies; imported by every module of the block.
package slfl_pkg;

    // Node store geometry; a slot pointer equal to SLOTS means null
    localparam int SLOTS       = 16;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int PTR_W       = $clog2(SLOTS + 1);
    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = 8;

    typedef logic [PTR_W-1:0]        ptr_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic signed [KEY_W-1:0] key_t;

    localparam ptr_t NIL = PTR_W'(SLOTS);

    // Operation carried in tuser
    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_DELETE = 1'b1
    } func_t;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // Sequencer to node store: write ports and shared read address
    typedef struct packed {
        logic key_we;
        idx_t key_waddr;
        key_t key_wdata;
        logic link_we;
        idx_t link_waddr;
        ptr_t link_wdata;
        idx_t raddr;
    } store_req_t;

endpackage

[design/slfl_store.sv]
// Node store: key memory and link memory with one shared registered read port.
// Link entries read as "next slot" until first written. Depends on slfl_pkg.
module slfl_store
    import slfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output key_t       rd_key,
    output ptr_t       rd_link
);

    key_t             key_mem_reg  [SLOTS];
    ptr_t             link_mem_reg [SLOTS];
    logic [SLOTS-1:0] link_vld_reg;
    key_t             rd_key_reg;
    ptr_t             rd_link_reg;

    // Memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (req.key_we)
        begin
            key_mem_reg[req.key_waddr] <= req.key_wdata;
        end
        if (req.link_we)
        begin
            link_mem_reg[req.link_waddr] <= req.link_wdata;
        end
        rd_key_reg <= key_mem_reg[req.raddr];
        if (link_vld_reg[req.raddr])
        begin
            rd_link_reg <= link_mem_reg[req.raddr];
        end
        else
        begin
            // unwritten link: slot i points at slot i+1, last at null
            rd_link_reg <= ptr_t'(req.raddr) + ptr_t'(1);
        end
    end

    // Per-entry written flags for the link memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg <= '0;
        end
        else if (req.link_we)
        begin
            link_vld_reg[req.link_waddr] <= 1'b1;
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_link = rd_link_reg;

endmodule

[design/slfl_cmp.sv]
// Shared key comparator used at every step of a list walk.
// Signed less-than and equality. Depends on slfl_pkg.
module slfl_cmp
    import slfl_pkg::*;
(
    input  key_t node_key,
    input  key_t ref_key,
    output logic less,
    output logic equal
);

    assign less  = (node_key < ref_key);
    assign equal = (node_key == ref_key);

endmodule

[design/sorted_list_with_free_list_top.sv]
// Sorted list with free list: top level with the walk sequencer.
// Uses slfl_pkg, slfl_store and slfl_cmp.
// Usage:
//   Input channel s_axis: one word per operation. s_axis_tuser selects insert
//   or delete, s_axis_tdata carries the signed 32-bit key. Output channel
//   m_axis: one status word per operation (done, full, not found).
//   Keys are kept in ascending order in a 16-slot node store linked by slot
//   indices; insert puts a key before the first key >= it, delete removes the
//   first equal key and returns its slot to the free list.
// Throughput:
//   The walk reads one node per cycle through the single store read port and
//   the shared comparator. Insert: alloc, walk (if the list is non-empty),
//   link-new, link-prev; delete that finds its key: walk, unlink, release;
//   delete that misses: walk only. A full store or a delete on an empty list
//   raises m_axis_tvalid on the accepting edge. One operation at a time;
//   s_axis_tready is high only while the sequencer is idle.
// Reset:
//   rst_n (async, active low) empties the list and chains all slots onto the
//   free list at once; the block accepts words on the first cycle after reset.
// Stall:
//   The status sits in an output register; while it waits for m_axis_tready
//   no new word is accepted.
module sorted_list_with_free_list_top
    import slfl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [KEY_W-1:0]       s_axis_tdata,  // [31:0] key
    input  logic [0:0]             s_axis_tuser,  // [0] func
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [1:0] status, rest zero
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_ALLOC     = 7'b0000010,
        S_WALK      = 7'b0000100,
        S_LINK_NEW  = 7'b0001000,
        S_LINK_PREV = 7'b0010000,
        S_UNLINK    = 7'b0100000,
        S_RELEASE   = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    func_t      func_reg, func_next;
    key_t       key_reg, key_next;
    idx_t       slot_reg, slot_next;
    ptr_t       pres_reg, pres_next;
    ptr_t       prev_reg, prev_next;
    ptr_t       after_reg, after_next;
    ptr_t       free_reg, free_next;
    ptr_t       head_reg, head_next;
    logic       out_valid_reg, out_valid_next;
    status_t    status_reg, status_next;

    store_req_t req;
    key_t       rd_key;
    ptr_t       rd_link;
    logic       less;
    logic       equal;
    logic       accept;
    logic       load;
    status_t    load_status;
    logic       advance;

    slfl_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_key  (rd_key),
        .rd_link (rd_link)
    );

    slfl_cmp u_cmp (
        .node_key (rd_key),
        .ref_key  (key_reg),
        .less     (less),
        .equal    (equal)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    // walk continues past nodes that are smaller (insert) or unequal (delete)
    assign advance       = (func_reg == FN_INSERT) ? less : !equal;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        slot_next   = slot_reg;
        pres_next   = pres_reg;
        prev_next   = prev_reg;
        after_next  = after_reg;
        free_next   = free_reg;
        head_next   = head_reg;
        load        = 1'b0;
        load_status = ST_DONE;

        req            = '0;
        req.key_wdata  = key_reg;
        req.raddr      = pres_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = func_t'(s_axis_tuser[0]);
                    key_next  = key_t'(s_axis_tdata);
                    if (func_t'(s_axis_tuser[0]) == FN_INSERT)
                    begin
                        if (free_reg == NIL)
                        begin
                            load        = 1'b1;
                            load_status = ST_FULL;
                        end
                        else
                        begin
                            // claim free head: store key, fetch its link
                            req.key_we    = 1'b1;
                            req.key_waddr = free_reg[IDX_W-1:0];
                            req.key_wdata = key_t'(s_axis_tdata);
                            req.raddr     = free_reg[IDX_W-1:0];
                            slot_next     = free_reg[IDX_W-1:0];
                            state_next    = S_ALLOC;
                        end
                    end
                    else
                    begin
                        if (head_reg == NIL)
                        begin
                            load        = 1'b1;
                            load_status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            req.raddr  = head_reg[IDX_W-1:0];
                            pres_next  = head_reg;
                            prev_next  = NIL;
                            state_next = S_WALK;
                        end
                    end
                end
            end

            S_ALLOC:
            begin
                free_next = rd_link;
                prev_next = NIL;
                pres_next = head_reg;
                if (head_reg != NIL)
                begin
                    req.raddr  = head_reg[IDX_W-1:0];
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_LINK_NEW;
                end
            end

            // one node per cycle: read data of pres_reg is valid here
            S_WALK:
            begin
                if (advance)
                begin
                    prev_next = pres_reg;
                    pres_next = rd_link;
                    if (rd_link != NIL)
                    begin
                        req.raddr = rd_link[IDX_W-1:0];
                    end
                    else if (func_reg == FN_INSERT)
                    begin
                        state_next = S_LINK_NEW;
                    end
                    else
                    begin
                        load        = 1'b1;
                        load_status = ST_NOT_FOUND;
                        state_next  = S_IDLE;
                    end
                end
                else if (func_reg == FN_INSERT)
                begin
                    state_next = S_LINK_NEW;
                end
                else
                begin
                    after_next = rd_link;
                    state_next = S_UNLINK;
                end
            end

            S_LINK_NEW:
            begin
                req.link_we    = 1'b1;
                req.link_waddr = slot_reg;
                req.link_wdata = pres_reg;
                state_next     = S_LINK_PREV;
            end

            S_LINK_PREV:
            begin
                if (prev_reg == NIL)
                begin
                    head_next = ptr_t'(slot_reg);
                end
                else
                begin
                    req.link_we    = 1'b1;
                    req.link_waddr = prev_reg[IDX_W-1:0];
                    req.link_wdata = ptr_t'(slot_reg);
                end
                load       = 1'b1;
                state_next = S_IDLE;
            end

            S_UNLINK:
            begin
                if (prev_reg == NIL)
                begin
                    head_next = after_reg;
                end
                else
                begin
                    req.link_we    = 1'b1;
                    req.link_waddr = prev_reg[IDX_W-1:0];
                    req.link_wdata = after_reg;
                end
                state_next = S_RELEASE;
            end

            // push the removed slot onto the free list
            S_RELEASE:
            begin
                req.link_we    = 1'b1;
                req.link_waddr = pres_reg[IDX_W-1:0];
                req.link_wdata = free_reg;
                free_next      = pres_reg;
                load           = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            status_next    = load_status;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_reg      <= '0;
            head_reg      <= NIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        slot_reg   <= slot_next;
        pres_reg   <= pres_next;
        prev_reg   <= prev_next;
        after_reg  <= after_next;
        status_reg <= status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-STATUS_W){1'b0}}, status_reg};

endmodule

[design/slfl_checker.sv]
// Port-level checker for the sorted list block, bound to the top level.
// Depends on slfl_pkg and sorted_list_with_free_list_top.
module slfl_checker
    import slfl_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [KEY_W-1:0]       s_axis_tdata,
    input logic [0:0]             s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Stalled status word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("status word changed while stalled");

    // No new operation while a status word is stuck in the output register
    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // Status code is a known one and padding is zero
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[STATUS_W-1:0] == ST_DONE ||
             m_axis_tdata[STATUS_W-1:0] == ST_FULL ||
             m_axis_tdata[STATUS_W-1:0] == ST_NOT_FOUND) &&
            (m_axis_tdata[OUT_TDATA_W-1:STATUS_W] == '0))
        else $error("bad status word");

    // Busy after taking a word that needs a walk: no back-to-back accepts on a
    // non-empty walk, so a new accept cannot follow a delete-key walk start
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=>
            !(s_axis_tvalid && s_axis_tready) || m_axis_tvalid)
        else $error("second word accepted while first still in work");

endmodule

bind sorted_list_with_free_list_top slfl_checker u_slfl_checker (.*);

[tb/sv/sorted_list_with_free_list_top_test.sv]
// Testbench for sorted_list_with_free_list_top: directed and random insert/delete
// streams checked against an in-bench model of the sorted list and its free list.
// Depends on slfl_pkg and the RTL of the block only.
module sorted_list_with_free_list_top_test
    import slfl_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Receiver behavior selectors
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    // Key choice for the random streams
    localparam int KEYS_NARROW = 0;
    localparam int KEYS_WIDE   = 1;

    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 30;
    localparam int CYCLE_LIMIT   = 400000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [KEY_W-1:0]       s_axis_tdata = '0;   // [31:0] key
    logic [0:0]             s_axis_tuser = '0;   // [0] func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [1:0] status, rest zero

    // Model of the node store
    key_t node_key  [SLOTS];
    ptr_t node_link [SLOTS];
    ptr_t free_top;
    ptr_t list_head;

    status_t expected_status[$];
    int      error_count = 0;
    int      cycle_count = 0;

    // Receiver control
    int rx_mode = RX_ALWAYS;
    int rx_phase = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    // Sender burst bookkeeping
    int burst_left = 0;

    sorted_list_with_free_list_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Empty list, every slot chained onto the free list
    task automatic clear_model();
        for (int i = 0; i < SLOTS; i++)
        begin
            node_key[i]  = '0;
            node_link[i] = ptr_t'(i + 1);
        end
        free_top  = '0;
        list_head = NIL;
    endtask

    // Apply one operation to the model and return its status
    function automatic status_t predict_status(func_t op, key_t k);
        ptr_t prev;
        ptr_t pres;
        ptr_t slot;
        int   steps;
        prev  = NIL;
        pres  = list_head;
        steps = 0;
        if (op == FN_INSERT)
        begin
            if (free_top >= NIL)
                return ST_FULL;
            slot = free_top;
            free_top = node_link[slot[IDX_W-1:0]];
            node_key[slot[IDX_W-1:0]] = k;
            // new key goes before the first key >= it
            while (pres < NIL && steps < SLOTS && node_key[pres[IDX_W-1:0]] < k)
            begin
                prev = pres;
                pres = node_link[pres[IDX_W-1:0]];
                steps++;
            end
            if (prev >= NIL)
                list_head = slot;
            else
                node_link[prev[IDX_W-1:0]] = slot;
            node_link[slot[IDX_W-1:0]] = pres;
            return ST_DONE;
        end
        // delete: first equal key
        while (pres < NIL && steps < SLOTS && node_key[pres[IDX_W-1:0]] != k)
        begin
            prev = pres;
            pres = node_link[pres[IDX_W-1:0]];
            steps++;
        end
        if (pres >= NIL || steps >= SLOTS)
            return ST_NOT_FOUND;
        if (prev >= NIL)
            list_head = node_link[pres[IDX_W-1:0]];
        else
            node_link[prev[IDX_W-1:0]] = node_link[pres[IDX_W-1:0]];
        node_link[pres[IDX_W-1:0]] = free_top;
        free_top = pres;
        return ST_DONE;
    endfunction

    // A key currently on the list, or a random one if the list is empty
    function automatic key_t pick_live_key();
        ptr_t p;
        int   count;
        int   pick;
        count = 0;
        p = list_head;
        while (p < NIL && count < SLOTS)
        begin
            count++;
            p = node_link[p[IDX_W-1:0]];
        end
        if (count == 0)
            return key_t'($urandom());
        pick = $urandom_range(0, count - 1);
        p = list_head;
        for (int i = 0; i < pick; i++)
            p = node_link[p[IDX_W-1:0]];
        return node_key[p[IDX_W-1:0]];
    endfunction

    // Offer one word and hold it until accepted; expectation is queued on accept
    task automatic send_word(input func_t op, input key_t k);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= k;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_status.push_back(predict_status(op, k));
    endtask

    task automatic idle_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Bursts of random length separated by random gaps
    task automatic pace_sender();
        if (burst_left == 0)
        begin
            idle_sender($urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Random stream: ins_pct percent inserts, deletes hit a stored key live_pct percent
    task automatic run_random(input int count, input int ins_pct, input int key_mode,
                              input int live_pct, input bit paced);
        func_t op;
        key_t  k;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(0, 99) < ins_pct) ? FN_INSERT : FN_DELETE;
            if (key_mode == KEYS_NARROW)
            begin
                case ($urandom_range(0, 9))
                    0:       k = key_t'(32'h8000_0000);
                    1:       k = key_t'(32'h7fff_ffff);
                    default: k = key_t'($urandom_range(0, 15)) - key_t'(8);
                endcase
            end
            else
            begin
                k = key_t'($urandom());
            end
            if (op == FN_DELETE && $urandom_range(0, 99) < live_pct)
                k = pick_live_key();
            send_word(op, k);
            if (paced)
                pace_sender();
        end
    endtask

    // Receiver: long hold on request, otherwise its own stall pattern
    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 1;
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= ($urandom_range(0, 9) >= 3);
                default:   m_axis_tready <= ((rx_phase % 7) < 4);
            endcase
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        status_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = status_t'(m_axis_tdata[STATUS_W-1:0]);
            if (expected_status.size() == 0)
            begin
                $error("unexpected word: status %0d with nothing pending", got);
                error_count++;
            end
            else if (got != expected_status[0])
            begin
                $error("status mismatch: expected %0d, actual %0d", expected_status[0], got);
                error_count++;
                void'(expected_status.pop_front());
            end
            else
            begin
                void'(expected_status.pop_front());
            end
        end
    end

    // Empty list, extreme keys, duplicates, absent keys
    task automatic test_directed_extremes();
        rx_mode <= RX_ALWAYS;
        send_word(FN_DELETE, key_t'(0));
        send_word(FN_INSERT, key_t'(32'h8000_0000));
        send_word(FN_INSERT, key_t'(32'h7fff_ffff));
        send_word(FN_INSERT, key_t'(0));
        send_word(FN_INSERT, key_t'(-1));
        send_word(FN_INSERT, key_t'(-1));
        send_word(FN_DELETE, key_t'(5));
        send_word(FN_DELETE, key_t'(-1));
        send_word(FN_DELETE, key_t'(32'h8000_0000));
        send_word(FN_DELETE, key_t'(32'h7fff_ffff));
    endtask

    // Fill the store, then one insert too many
    task automatic test_directed_full();
        rx_mode <= RX_RANDOM;
        for (int i = 0; i < SLOTS - 2; i++)
            send_word(FN_INSERT, key_t'($urandom()));
        send_word(FN_INSERT, key_t'(3));
    endtask

    // Many collisions: equal keys and deletes that mostly hit
    task automatic test_random_narrow();
        rx_mode <= RX_RANDOM;
        run_random(400, 55, KEYS_NARROW, 50, 1'b1);
    endtask

    // Long receiver hold while words keep coming back to back
    task automatic test_backpressure();
        rx_mode <= RX_PATTERN;
        hold_requests <= hold_requests + 1;
        run_random(60, 60, KEYS_WIDE, 70, 1'b0);
    endtask

    // Full 32-bit keys, deletes drawn from the stored keys
    task automatic test_random_wide();
        rx_mode <= RX_PATTERN;
        run_random(400, 55, KEYS_WIDE, 70, 1'b1);
    endtask

    // Swing between full and empty several times
    task automatic test_fill_drain();
        rx_mode <= RX_RANDOM;
        for (int r = 0; r < 5; r++)
        begin
            run_random(25, 85, KEYS_WIDE, 80, 1'b1);
            run_random(25, 15, KEYS_NARROW, 80, 1'b1);
        end
        rx_mode <= RX_ALWAYS;
        run_random(30, 50, KEYS_NARROW, 60, 1'b0);
    endtask

    initial
    begin
        clear_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_directed_full();
        test_random_narrow();
        test_backpressure();
        test_random_wide();
        test_fill_drain();

        // Let the last results come out
        s_axis_tvalid <= 1'b0;
        rx_mode <= RX_ALWAYS;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
